@@ design/rtp_receiver_statistics_core_macros.svh @@
// Assertion macros shared by the RTP receiver statistics design.
`ifndef RTP_RECEIVER_STATISTICS_CORE_MACROS_SVH
`define RTP_RECEIVER_STATISTICS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RTPSTAT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RTPSTAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RTPSTAT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RTPSTAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ design/rtpstat_pkg.sv @@
// Package with types, codes and constants of the RTP receiver statistics block.
package rtpstat_pkg;

    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_REPORT = 2'd1,
        OP_SENDER = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_FOREIGN  = 2'd1;
    localparam logic [1:0] ST_CORRUPT  = 2'd2;

    localparam logic [1:0] CHK_FINE      = 2'd0;
    localparam logic [1:0] CHK_COLLISION = 2'd1;

    localparam logic [31:0] USEC_PER_SEC  = 32'd1000000;
    localparam logic [31:0] TENTH_MS      = 32'd10000;
    localparam logic [31:0] TENTH_MS_RECIP = 32'hD1B71759;
    localparam logic [35:0] JITTER_LIMIT  = 36'd256000000;
    localparam logic [19:0] RATE_RESET    = 20'd8000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_RES_WAIT,
        S_PKT_UPD,
        S_JIT_MUL,
        S_JIT_DIV,
        S_JIT_WAIT,
        S_RPT_LOSS,
        S_FRAC_WAIT,
        S_RPT_SCALE,
        S_SCALE_WAIT,
        S_RPT_DSEC,
        S_DSEC_WAIT,
        S_RPT_DFRAC,
        S_DFRAC_WAIT,
        S_OUTPUT
    } state_t;

    typedef enum logic [2:0] {
        DIV_RES,
        DIV_JIT,
        DIV_FRAC,
        DIV_SCALE,
        DIV_DSEC,
        DIV_DFRAC
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     eval;
        logic     div_start;
        logic     recip_load;
        div_sel_t div_sel;
        logic     pkt_update;
        logic     jit_mul;
        logic     jit_update;
        logic     rpt_loss;
        logic     frac_load;
        logic     scale_load;
        logic     dsec_load;
        logic     dfrac_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic pkt_ok;
        logic need_res;
        logic same_stamp;
        logic frac_needed;
        logic res_nonzero;
        logic div_busy;
        logic div_done;
    } sts_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        assign_stream;
        logic        header_valid;
        logic        address_ok;
        logic [1:0]  source_check;
        logic [31:0] source_id;
        logic [15:0] seq_number;
        logic [31:0] media_timestamp;
        logic [6:0]  payload_kind;
        logic [31:0] local_time;
        logic [31:0] ntp_seconds;
        logic [31:0] ntp_fraction;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] extended_seq;
        logic [31:0] cumulative_lost;
        logic [7:0]  fraction_lost;
        logic [31:0] jitter_ticks;
        logic [31:0] jitter_scaled;
        logic [31:0] last_sr_stamp;
        logic [31:0] delay_since_sr;
        logic [31:0] remote_source;
    } rsp_t;

endpackage

@@ design/rtpstat_if.sv @@
// Channel interfaces for requests, results and the configuration write.
interface rtpstat_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic        assign_stream;
    logic        header_valid;
    logic        address_ok;
    logic [1:0]  source_check;
    logic [31:0] source_id;
    logic [15:0] seq_number;
    logic [31:0] media_timestamp;
    logic [6:0]  payload_kind;
    logic [31:0] local_time;
    logic [31:0] ntp_seconds;
    logic [31:0] ntp_fraction;
    modport source (output valid, op, assign_stream, header_valid, address_ok, source_check,
        source_id, seq_number, media_timestamp, payload_kind, local_time, ntp_seconds,
        ntp_fraction, input ready);
    modport sink (input valid, op, assign_stream, header_valid, address_ok, source_check,
        source_id, seq_number, media_timestamp, payload_kind, local_time, ntp_seconds,
        ntp_fraction, output ready);
endinterface

interface rtpstat_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] extended_seq;
    logic [31:0] cumulative_lost;
    logic [7:0]  fraction_lost;
    logic [31:0] jitter_ticks;
    logic [31:0] jitter_scaled;
    logic [31:0] last_sr_stamp;
    logic [31:0] delay_since_sr;
    logic [31:0] remote_source;
    modport source (output valid, status, extended_seq, cumulative_lost, fraction_lost,
        jitter_ticks, jitter_scaled, last_sr_stamp, delay_since_sr, remote_source,
        input ready);
    modport sink (input valid, status, extended_seq, cumulative_lost, fraction_lost,
        jitter_ticks, jitter_scaled, last_sr_stamp, delay_since_sr, remote_source,
        output ready);
endinterface

interface rtpstat_cfg_if;
    logic        valid;
    logic        ready;
    logic [19:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ design/rtpstat_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module rtpstat_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dsr_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [33:0] diff;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 32'd0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/rtpstat_dp.sv @@
// Datapath: stream state, packet checks, jitter and report arithmetic.
module rtpstat_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  rtpstat_pkg::req_t   req,
    output rtpstat_pkg::rsp_t   rsp,
    input  logic                cfg_we,
    input  logic [19:0]         cfg_data,
    input  rtpstat_pkg::cmd_t   cmd,
    output rtpstat_pkg::sts_t   sts
);

    rtpstat_pkg::req_t in_reg;

    logic [19:0] rate_reg;
    logic [31:0] locked_source_reg;
    logic        first_reg;
    logic [6:0]  locked_payload_reg;
    logic [15:0] base_seq_reg;
    logic [15:0] highest_seq_reg;
    logic [15:0] seq_cycles_reg;
    logic [31:0] received_reg;
    logic [15:0] wraps_reg;
    logic [31:0] prior_exp_reg;
    logic [31:0] prior_rec_reg;
    logic [19:0] res_reg;
    logic [31:0] jitter_q4_reg;
    logic [31:0] last_arrival_reg;
    logic [31:0] last_media_reg;
    logic [31:0] sr_seconds_reg;
    logic [31:0] sr_fraction_reg;
    logic [31:0] sr_local_reg;

    logic [31:0] prod_reg;
    logic [15:0] dsec_q_reg;
    logic [13:0] dsec_r_reg;
    logic [31:0] recip_x_reg;
    logic [63:0] recip_prod_reg;

    rtpstat_pkg::rsp_t rsp_reg;

    logic [1:0]  eval_status;
    logic        newer;
    logic [15:0] seq_gap;
    logic [31:0] ext;
    logic [31:0] expected;
    logic [15:0] wraps_next;
    logic [31:0] exp_adj;
    logic [31:0] cum;
    logic [31:0] iexp;
    logic [31:0] ilost;
    logic [31:0] ticks;
    logic [45:0] scale_prod;
    logic [51:0] jit_prod;
    logic [31:0] jit_d;
    logic [31:0] jit_mag;
    logic [35:0] jit_num;
    logic [31:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_busy;
    logic        div_done;
    logic [31:0] div_q;
    logic [31:0] recip_x;
    logic [31:0] recip_q;
    logic [32:0] recip_back;
    logic [31:0] recip_r;

    rtpstat_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q)
    );

    always_comb
    begin
        eval_status = rtpstat_pkg::ST_ACCEPTED;
        if (in_reg.assign_stream ? (locked_source_reg != 32'd0)
                                 : (locked_source_reg != in_reg.source_id))
            eval_status = rtpstat_pkg::ST_FOREIGN;
        else if (!in_reg.header_valid)
            eval_status = rtpstat_pkg::ST_CORRUPT;
        else if (!in_reg.address_ok)
            eval_status = rtpstat_pkg::ST_FOREIGN;
        else if (in_reg.source_check != rtpstat_pkg::CHK_FINE &&
                 in_reg.source_check != rtpstat_pkg::CHK_COLLISION)
            eval_status = rtpstat_pkg::ST_FOREIGN;
        else if (!first_reg && in_reg.source_check != rtpstat_pkg::CHK_COLLISION &&
                 locked_source_reg != in_reg.source_id)
            eval_status = rtpstat_pkg::ST_FOREIGN;
    end

    assign seq_gap = highest_seq_reg - in_reg.seq_number;
    assign newer   = first_reg || seq_gap[15];

    always_comb
    begin
        ext      = {seq_cycles_reg, highest_seq_reg};
        expected = ext - {16'd0, base_seq_reg} + 32'd1;
        if (expected < received_reg)
        begin
            wraps_next = wraps_reg;
            exp_adj    = expected;
            cum        = 32'd0;
        end
        else
        begin
            wraps_next = ((expected + {wraps_reg, 16'd0}) < prior_exp_reg)
                         ? wraps_reg + 16'd1 : wraps_reg;
            exp_adj    = expected + {wraps_next, 16'd0};
            cum        = exp_adj - received_reg;
        end
        iexp  = exp_adj - prior_exp_reg;
        ilost = iexp - (received_reg - prior_rec_reg);
    end

    assign ticks      = {4'd0, jitter_q4_reg[31:4]};
    assign scale_prod = ticks * 14'd10000;
    assign jit_prod   = (in_reg.local_time - last_arrival_reg) * res_reg;
    assign jit_d      = recip_q - (in_reg.media_timestamp - last_media_reg);
    assign jit_mag    = jit_d[31] ? (32'd0 - jit_d) : jit_d;
    assign jit_num    = 36'd15 * {4'd0, jitter_q4_reg} + {jit_mag, 4'd0};

    assign recip_q    = {13'd0, recip_prod_reg[63:45]};
    assign recip_back = recip_prod_reg[63:45] * rtpstat_pkg::TENTH_MS[13:0];
    assign recip_r    = recip_x_reg - recip_back[31:0];

    always_comb
    begin
        case (cmd.div_sel)
            rtpstat_pkg::DIV_RES:
            begin
                div_dividend = rtpstat_pkg::USEC_PER_SEC;
                div_divisor  = {12'd0, rate_reg};
            end
            rtpstat_pkg::DIV_FRAC:
            begin
                div_dividend = {ilost[23:0], 8'd0};
                div_divisor  = iexp;
            end
            rtpstat_pkg::DIV_SCALE:
            begin
                div_dividend = scale_prod[31:0];
                div_divisor  = {12'd0, res_reg};
            end
            default:
            begin
                div_dividend = 32'd0;
                div_divisor  = rtpstat_pkg::TENTH_MS;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.div_sel)
            rtpstat_pkg::DIV_DSEC:
                recip_x = in_reg.local_time - sr_local_reg;
            rtpstat_pkg::DIV_DFRAC:
                recip_x = {2'd0, dsec_r_reg, 16'd0};
            default:
                recip_x = prod_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg           <= rtpstat_pkg::RATE_RESET;
            locked_source_reg  <= 32'd0;
            first_reg          <= 1'b1;
            locked_payload_reg <= 7'd0;
            base_seq_reg       <= 16'd0;
            highest_seq_reg    <= 16'd0;
            seq_cycles_reg     <= 16'd0;
            received_reg       <= 32'd0;
            wraps_reg          <= 16'd0;
            prior_exp_reg      <= 32'd0;
            prior_rec_reg      <= 32'd0;
            res_reg            <= 20'd0;
            jitter_q4_reg      <= 32'd0;
            last_arrival_reg   <= 32'd0;
            last_media_reg     <= 32'd0;
            sr_seconds_reg     <= 32'd0;
            sr_fraction_reg    <= 32'd0;
            sr_local_reg       <= 32'd0;
        end
        else
        begin
            if (cfg_we)
                rate_reg <= cfg_data;
            if (cmd.eval)
            begin
                if (in_reg.op == rtpstat_pkg::OP_SENDER && in_reg.header_valid)
                begin
                    sr_local_reg    <= in_reg.local_time;
                    sr_seconds_reg  <= in_reg.ntp_seconds;
                    sr_fraction_reg <= in_reg.ntp_fraction;
                end
                if (in_reg.op == rtpstat_pkg::OP_CLEAR)
                begin
                    received_reg     <= 32'd0;
                    wraps_reg        <= 16'd0;
                    jitter_q4_reg    <= 32'd0;
                    last_arrival_reg <= 32'd0;
                    last_media_reg   <= 32'd0;
                    sr_seconds_reg   <= 32'd0;
                    sr_fraction_reg  <= 32'd0;
                    sr_local_reg     <= 32'd0;
                end
            end
            if (cmd.pkt_update)
            begin
                if (first_reg || in_reg.source_check == rtpstat_pkg::CHK_COLLISION)
                    locked_source_reg <= in_reg.source_id;
                if (first_reg)
                begin
                    locked_payload_reg <= in_reg.payload_kind;
                    base_seq_reg       <= in_reg.seq_number;
                    res_reg            <= (rate_reg != 20'd0) ? div_q[19:0] : 20'd0;
                end
                if (newer)
                begin
                    if (!first_reg && in_reg.seq_number < highest_seq_reg)
                        seq_cycles_reg <= seq_cycles_reg + 16'd1;
                    highest_seq_reg <= in_reg.seq_number;
                    first_reg       <= 1'b0;
                    received_reg    <= received_reg + 32'd1;
                end
            end
            if (cmd.jit_update)
            begin
                jitter_q4_reg    <= (jit_num > rtpstat_pkg::JITTER_LIMIT)
                                    ? 32'd0 : jit_num[35:4];
                last_arrival_reg <= in_reg.local_time;
                last_media_reg   <= in_reg.media_timestamp;
            end
            if (cmd.rpt_loss)
            begin
                wraps_reg     <= wraps_next;
                prior_exp_reg <= exp_adj;
                prior_rec_reg <= received_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg  <= req;
            rsp_reg <= '0;
        end
        if (cmd.eval)
        begin
            if (in_reg.op == rtpstat_pkg::OP_PACKET)
                rsp_reg.status <= eval_status;
            else if (in_reg.op == rtpstat_pkg::OP_SENDER && !in_reg.header_valid)
                rsp_reg.status <= rtpstat_pkg::ST_CORRUPT;
        end
        if (cmd.jit_mul)
            prod_reg <= jit_prod[31:0];
        if (cmd.recip_load)
        begin
            recip_x_reg    <= recip_x;
            recip_prod_reg <= recip_x * rtpstat_pkg::TENTH_MS_RECIP;
        end
        if (cmd.rpt_loss)
        begin
            rsp_reg.extended_seq    <= ext;
            rsp_reg.cumulative_lost <= cum;
            rsp_reg.jitter_ticks    <= ticks;
            rsp_reg.last_sr_stamp   <= {sr_seconds_reg[15:0], sr_fraction_reg[31:16]};
            rsp_reg.remote_source   <= locked_source_reg;
        end
        if (cmd.frac_load)
            rsp_reg.fraction_lost <= div_q[7:0];
        if (cmd.scale_load)
            rsp_reg.jitter_scaled <= div_q;
        if (cmd.dsec_load)
        begin
            dsec_q_reg <= recip_q[15:0];
            dsec_r_reg <= recip_r[13:0];
        end
        if (cmd.dfrac_load)
            rsp_reg.delay_since_sr <= {dsec_q_reg, 16'd0} + recip_q;
    end

    assign rsp = rsp_reg;

    always_comb
    begin
        sts.op          = rtpstat_pkg::op_t'(in_reg.op);
        sts.pkt_ok      = (eval_status == rtpstat_pkg::ST_ACCEPTED);
        sts.need_res    = first_reg && (rate_reg != 20'd0);
        sts.same_stamp  = (in_reg.media_timestamp == last_media_reg);
        sts.frac_needed = (iexp != 32'd0) && (ilost != 32'd0);
        sts.res_nonzero = (res_reg != 20'd0);
        sts.div_busy    = div_busy;
        sts.div_done    = div_done;
    end

endmodule

@@ design/rtpstat_ctrl.sv @@
// Controller state machine sequencing the datapath for each operation.
`include "rtp_receiver_statistics_core_macros.svh"
module rtpstat_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rtpstat_pkg::cmd_t cmd,
    input  rtpstat_pkg::sts_t sts
);

    rtpstat_pkg::state_t state_reg;
    rtpstat_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rtpstat_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = rtpstat_pkg::DIV_RES;
        req_ready   = 1'b0;
        rsp_valid   = 1'b0;
        unique case (state_reg)
            rtpstat_pkg::S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                    state_next = rtpstat_pkg::S_EVAL;
            end
            rtpstat_pkg::S_EVAL:
            begin
                cmd.eval = 1'b1;
                case (sts.op)
                    rtpstat_pkg::OP_PACKET:
                    begin
                        if (!sts.pkt_ok)
                            state_next = rtpstat_pkg::S_OUTPUT;
                        else if (sts.need_res)
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = rtpstat_pkg::DIV_RES;
                            state_next    = rtpstat_pkg::S_RES_WAIT;
                        end
                        else
                            state_next = rtpstat_pkg::S_PKT_UPD;
                    end
                    rtpstat_pkg::OP_REPORT:
                        state_next = rtpstat_pkg::S_RPT_LOSS;
                    default:
                        state_next = rtpstat_pkg::S_OUTPUT;
                endcase
            end
            rtpstat_pkg::S_RES_WAIT:
            begin
                if (sts.div_done)
                    state_next = rtpstat_pkg::S_PKT_UPD;
            end
            rtpstat_pkg::S_PKT_UPD:
            begin
                cmd.pkt_update = 1'b1;
                state_next = sts.same_stamp ? rtpstat_pkg::S_OUTPUT : rtpstat_pkg::S_JIT_MUL;
            end
            rtpstat_pkg::S_JIT_MUL:
            begin
                cmd.jit_mul = 1'b1;
                state_next  = rtpstat_pkg::S_JIT_DIV;
            end
            rtpstat_pkg::S_JIT_DIV:
            begin
                cmd.recip_load = 1'b1;
                cmd.div_sel    = rtpstat_pkg::DIV_JIT;
                state_next     = rtpstat_pkg::S_JIT_WAIT;
            end
            rtpstat_pkg::S_JIT_WAIT:
            begin
                cmd.jit_update = 1'b1;
                state_next     = rtpstat_pkg::S_OUTPUT;
            end
            rtpstat_pkg::S_RPT_LOSS:
            begin
                cmd.rpt_loss = 1'b1;
                if (sts.frac_needed)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = rtpstat_pkg::DIV_FRAC;
                    state_next    = rtpstat_pkg::S_FRAC_WAIT;
                end
                else
                    state_next = rtpstat_pkg::S_RPT_SCALE;
            end
            rtpstat_pkg::S_FRAC_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.frac_load = 1'b1;
                    state_next    = rtpstat_pkg::S_RPT_SCALE;
                end
            end
            rtpstat_pkg::S_RPT_SCALE:
            begin
                if (sts.res_nonzero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = rtpstat_pkg::DIV_SCALE;
                    state_next    = rtpstat_pkg::S_SCALE_WAIT;
                end
                else
                    state_next = rtpstat_pkg::S_RPT_DSEC;
            end
            rtpstat_pkg::S_SCALE_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.scale_load = 1'b1;
                    state_next     = rtpstat_pkg::S_RPT_DSEC;
                end
            end
            rtpstat_pkg::S_RPT_DSEC:
            begin
                cmd.recip_load = 1'b1;
                cmd.div_sel    = rtpstat_pkg::DIV_DSEC;
                state_next     = rtpstat_pkg::S_DSEC_WAIT;
            end
            rtpstat_pkg::S_DSEC_WAIT:
            begin
                cmd.dsec_load = 1'b1;
                state_next    = rtpstat_pkg::S_RPT_DFRAC;
            end
            rtpstat_pkg::S_RPT_DFRAC:
            begin
                cmd.recip_load = 1'b1;
                cmd.div_sel    = rtpstat_pkg::DIV_DFRAC;
                state_next     = rtpstat_pkg::S_DFRAC_WAIT;
            end
            rtpstat_pkg::S_DFRAC_WAIT:
            begin
                cmd.dfrac_load = 1'b1;
                state_next     = rtpstat_pkg::S_OUTPUT;
            end
            rtpstat_pkg::S_OUTPUT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                    state_next = rtpstat_pkg::S_IDLE;
            end
            default:
                state_next = rtpstat_pkg::S_IDLE;
        endcase
    end

    `RTPSTAT_ASSERT_IMP(a_start_idle_div, clk, rst_n, cmd.div_start, !sts.div_busy)
    `RTPSTAT_ASSERT_IMP(a_no_overlap, clk, rst_n, req_ready, !rsp_valid)
    `RTPSTAT_ASSERT_NEXT(a_accept_evals, clk, rst_n, req_valid && req_ready, cmd.eval)
    `RTPSTAT_ASSERT_IMP(a_done_awaited, clk, rst_n, sts.div_done,
        state_reg == rtpstat_pkg::S_RES_WAIT || state_reg == rtpstat_pkg::S_FRAC_WAIT ||
        state_reg == rtpstat_pkg::S_SCALE_WAIT)

endmodule

@@ design/rtp_receiver_statistics_core.sv @@
// Top level of the RTP receiver statistics block.
// The request channel carries one operation per transfer: a parsed RTP
// header, a receiver report build, a sender report, or a statistics clear.
// Every request yields exactly one transfer on the response channel.
// The configuration channel writes the stream clock rate and is always ready.
// The block handles one request at a time; request ready is high only while
// it is idle, and a new request is taken once the response has been taken.
// A rejected packet, a sender report or a clear goes from evaluation
// straight to the response. An accepted packet updates the stream state
// and, unless the timestamp is unchanged, the jitter; on the first packet
// with a nonzero clock rate the resolution division comes first.
// A receiver report builds the loss counts and the loss fraction and jitter
// scaling divisions it needs, then the delay since the last sender report.
// The variable divisions share one 32-step divider; divisions by the
// constant 10000 use a reciprocal multiplication.
// After reset the clock rate is 8000 Hz, the stream is unlocked and the
// first packet locks it. While the response receiver stalls, the result is
// held and no request is taken.
module rtp_receiver_statistics_core (
    input logic           clk,
    input logic           rst_n,
    rtpstat_req_if.sink   request,
    rtpstat_rsp_if.source response,
    rtpstat_cfg_if.sink   cfg
);

    rtpstat_pkg::cmd_t cmd;
    rtpstat_pkg::sts_t sts;
    rtpstat_pkg::req_t req;
    rtpstat_pkg::rsp_t rsp;

    assign req.op              = request.op;
    assign req.assign_stream   = request.assign_stream;
    assign req.header_valid    = request.header_valid;
    assign req.address_ok      = request.address_ok;
    assign req.source_check    = request.source_check;
    assign req.source_id       = request.source_id;
    assign req.seq_number      = request.seq_number;
    assign req.media_timestamp = request.media_timestamp;
    assign req.payload_kind    = request.payload_kind;
    assign req.local_time      = request.local_time;
    assign req.ntp_seconds     = request.ntp_seconds;
    assign req.ntp_fraction    = request.ntp_fraction;

    assign response.status          = rsp.status;
    assign response.extended_seq    = rsp.extended_seq;
    assign response.cumulative_lost = rsp.cumulative_lost;
    assign response.fraction_lost   = rsp.fraction_lost;
    assign response.jitter_ticks    = rsp.jitter_ticks;
    assign response.jitter_scaled   = rsp.jitter_scaled;
    assign response.last_sr_stamp   = rsp.last_sr_stamp;
    assign response.delay_since_sr  = rsp.delay_since_sr;
    assign response.remote_source   = rsp.remote_source;

    assign cfg.ready = 1'b1;

    rtpstat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .rsp_valid (response.valid),
        .rsp_ready (response.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rtpstat_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.data),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
